[sv/dscc_pkg.sv]
// ----------------------------------------------------------------------------
// dscc_pkg
// Shared types, widths and register codes of the diagonal symbol chain counter.
// ----------------------------------------------------------------------------
package dscc_pkg;

	localparam int SIZE_W     = 9;
	localparam int SYM_W      = 8;
	localparam int SINGLE_W   = 17;
	localparam int PAIR_W     = 30;
	localparam int CHAIN_W    = 43;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 48;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_SYMBOL  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_SYMBOL = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_SYMBOL   = 3'd4;

	// Reset values of the registers.
	localparam logic [SIZE_W-1:0] GRID_SIZE_RST  = 9'd1;
	localparam logic [SYM_W-1:0]  FIRST_SYM_RST  = 8'd58;
	localparam logic [SYM_W-1:0]  MIDDLE_SYM_RST = 8'd45;
	localparam logic [SYM_W-1:0]  LAST_SYM_RST   = 8'd41;

	// One line buffer entry: prefix values of the three grids.
	typedef struct packed {
		logic [CHAIN_W-1:0]  chain;
		logic [PAIR_W-1:0]   pair;
		logic [SINGLE_W-1:0] single;
	} line_t;

	localparam int LINE_W = $bits(line_t);

	typedef struct packed {
		logic [SYM_W-1:0] first;
		logic [SYM_W-1:0] middle;
		logic [SYM_W-1:0] last;
	} sym_cfg_t;

	// Control that travels with a cell into the update stage.
	typedef struct packed {
		logic valid;
		logic has_up;
		logic has_left;
		logic last;
	} cell_ctl_t;

	// A size of zero acts as one, a size above the maximum as the maximum.
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[sv/diagonal_symbol_chain_counter.sv]
// ----------------------------------------------------------------------------
// diagonal_symbol_chain_counter
// Counts first-middle-last symbol chains running strictly down and right
// through a character grid that arrives in raster order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                       Transaction
//  s_axis    in         tdata[7:0]  symbol            one grid cell
//  m_axis    out        tdata[42:0] chain_count       one total per grid
//  cfg       in         cfg_addr index, cfg_data      one register write
//
// Cycles: one cell is taken in every cycle unless a stall holds it. A cell
// reads its column of the line buffer in the cycle it is accepted and is
// updated and written back in the next; the total of a grid is formed in the
// update stage from its last cell and registered into the output buffer. The
// pace is set by the single line buffer RAM, one read and one write per cycle.
// Reset: control state clears at once; the line buffer is not cleared, since
// the first row of a grid never reads it.
// Stalls: only the last cell of a grid waits, and only while the output
// register and its spare entry would both still hold earlier totals.
//
module diagonal_symbol_chain_counter
	import dscc_pkg::*;
#(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Configuration write channel.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// Grid cells.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] symbol
	// Chain totals.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata    // [42:0] chain_count, rest zero
);

	localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic               rd_en, wr_en;
	logic [AW-1:0]      rd_addr, wr_addr, addr_s1;
	logic [LINE_W-1:0]  rd_data, wr_data;
	cell_ctl_t          ctl_s1;
	logic [SYM_W-1:0]   sym_s1;
	sym_cfg_t           sym_cfg;
	logic [CHAIN_W-1:0] result, out_count;

	// Position tracking, configuration and the output buffer.
	dscc_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_symbol (s_axis_tdata[SYM_W-1:0]),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.ctl_s1    (ctl_s1),
		.addr_s1   (addr_s1),
		.sym_s1    (sym_s1),
		.sym_cfg   (sym_cfg),
		.result    (result),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_count (out_count)
	);

	// The previous row's prefix values of all three grids share one entry.
	dscc_ram #(
		.DATA_W (LINE_W),
		.DEPTH  (MAX_COLS)
	) u_line_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Read-modify-write of the cell against its up, left and diagonal values.
	dscc_update #(
		.AW (AW)
	) u_update (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s1  (ctl_s1),
		.addr_s1 (addr_s1),
		.sym_s1  (sym_s1),
		.sym_cfg (sym_cfg),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.result  (result)
	);

	assign m_axis_tdata = {{(OUT_TDATA_W - CHAIN_W){1'b0}}, out_count};

endmodule

[sv/dscc_ram.sv]
// ----------------------------------------------------------------------------
// dscc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module dscc_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 256,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[sv/dscc_ctrl.sv]
// ----------------------------------------------------------------------------
// dscc_ctrl
// Configuration registers, raster position, input flow control and the
// two-entry output buffer that holds finished chain totals.
// ----------------------------------------------------------------------------
module dscc_ctrl
	import dscc_pkg::*;
#(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256,
	localparam int AW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_addr,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [SYM_W-1:0]       in_symbol,
	output logic                   rd_en,
	output logic [AW-1:0]          rd_addr,
	output cell_ctl_t              ctl_s1,
	output logic [AW-1:0]          addr_s1,
	output logic [SYM_W-1:0]       sym_s1,
	output sym_cfg_t               sym_cfg,
	input  logic [CHAIN_W-1:0]     result,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CHAIN_W-1:0]     out_count
);

	logic [SIZE_W-1:0] rows_q, cols_q;
	logic [SIZE_W-1:0] rows_eff, cols_eff;
	sym_cfg_t          sym_q;
	logic [RW-1:0]     row_q;
	logic [AW-1:0]     col_q;
	logic              last_col, last_row, next_last;
	logic              accept, cfg_we, out_valid_q;
	logic [CHAIN_W-1:0] out_count_q;
	logic              spare_valid_q;
	logic [CHAIN_W-1:0] spare_count_q;
	logic              s1_last, out_pop;
	logic [1:0]        held_n;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid;

	assign rows_eff = clamp_size(rows_q, SIZE_W'(MAX_ROWS));
	assign cols_eff = clamp_size(cols_q, SIZE_W'(MAX_COLS));

	assign last_col  = (SIZE_W'(col_q) + SIZE_W'(1)) >= cols_eff;
	assign last_row  = (SIZE_W'(row_q) + SIZE_W'(1)) >= rows_eff;
	assign next_last = last_col && last_row;

	// Totals still held after this edge: both output entries plus the one in
	// the update stage, less the one that leaves now. Only the closing cell
	// of a grid can be held back, and only when no entry would be left for
	// its total once it leaves the update stage.
	assign s1_last  = ctl_s1.valid && ctl_s1.last;
	assign out_pop  = out_valid_q && out_ready;
	assign held_n   = 2'(out_valid_q) + 2'(spare_valid_q) + 2'(s1_last) - 2'(out_pop);
	assign in_ready = !(next_last && held_n[1]);
	assign accept   = in_valid && in_ready;

	assign rd_en   = accept;
	assign rd_addr = col_q;
	assign sym_cfg = sym_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q       <= GRID_SIZE_RST;
			cols_q       <= GRID_SIZE_RST;
			sym_q.first  <= FIRST_SYM_RST;
			sym_q.middle <= MIDDLE_SYM_RST;
			sym_q.last   <= LAST_SYM_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_GRID_ROWS:     rows_q       <= cfg_data;
				REG_GRID_COLS:     cols_q       <= cfg_data;
				REG_FIRST_SYMBOL:  sym_q.first  <= cfg_data[SYM_W-1:0];
				REG_MIDDLE_SYMBOL: sym_q.middle <= cfg_data[SYM_W-1:0];
				REG_LAST_SYMBOL:   sym_q.last   <= cfg_data[SYM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			if (cfg_we && (cfg_addr == REG_GRID_ROWS || cfg_addr == REG_GRID_COLS)) begin
				row_q <= '0;
				col_q <= '0;
			end else if (accept) begin
				ctl_s1.has_up   <= (row_q != '0);
				ctl_s1.has_left <= (col_q != '0);
				ctl_s1.last     <= next_last;
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + RW'(1);
				end else begin
					col_q <= col_q + AW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= col_q;
			sym_s1  <= in_symbol;
		end
	end

	// The head entry drives the port; the spare entry takes a total that is ready
	// while the head is waiting or the spare is full, and moves up once the head leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			spare_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q   <= spare_valid_q || s1_last;
			spare_valid_q <= spare_valid_q && s1_last;
		end else if (s1_last) begin
			spare_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (spare_valid_q) begin
				out_count_q <= spare_count_q;
			end else if (s1_last) begin
				out_count_q <= result;
			end
		end
		if (s1_last) begin
			spare_count_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_count = out_count_q;

endmodule

[sv/dscc_update.sv]
// ----------------------------------------------------------------------------
// dscc_update
// Prefix-sum update of one cell: up plus left minus diagonal for all three
// grids, with forwarding of a line buffer write that the next read misses.
// ----------------------------------------------------------------------------
module dscc_update
	import dscc_pkg::*;
#(
	parameter int AW = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctl_t          ctl_s1,
	input  logic [AW-1:0]      addr_s1,
	input  logic [SYM_W-1:0]   sym_s1,
	input  sym_cfg_t           sym_cfg,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	input  logic [LINE_W-1:0]  rd_data,
	output logic               wr_en,
	output logic [AW-1:0]      wr_addr,
	output logic [LINE_W-1:0]  wr_data,
	output logic [CHAIN_W-1:0] result
);

	line_t left_q, diag_q, fwd_q;
	logic  fwd_hit_q;
	line_t mem_val, up, lf, dg, nv;

	always_comb begin
		mem_val = fwd_hit_q ? fwd_q : line_t'(rd_data);
		up = ctl_s1.has_up ? mem_val : '0;
		lf = ctl_s1.has_left ? left_q : '0;
		dg = (ctl_s1.has_up && ctl_s1.has_left) ? diag_q : '0;

		nv.single = up.single + lf.single - dg.single;
		nv.pair   = up.pair + lf.pair - dg.pair;
		nv.chain  = up.chain + lf.chain - dg.chain;
		// Roles are tested independently, so one symbol may play several.
		if (sym_s1 == sym_cfg.first) begin
			nv.single = nv.single + SINGLE_W'(1);
		end
		if (sym_s1 == sym_cfg.middle) begin
			nv.pair = nv.pair + PAIR_W'(dg.single);
		end
		if (sym_s1 == sym_cfg.last) begin
			nv.chain = nv.chain + CHAIN_W'(dg.pair);
		end
	end

	assign wr_en   = ctl_s1.valid;
	assign wr_addr = addr_s1;
	assign wr_data = nv;
	assign result  = nv.chain;

	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			left_q <= nv;
			diag_q <= up;
		end
		fwd_q <= nv;
	end

	// A single-column grid reads the entry that is being written in the same
	// cycle; the RAM returns the old value, so the new one is taken from here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= wr_en && rd_en && (rd_addr == addr_s1);
		end
	end

endmodule
